// File: src/ftlb_pkg.sv
package ftlb_pkg;

	// Default geometry of the translation buffer
	localparam int ENTRIES_DEF    = 16;
	localparam int PAGE_BITS_DEF  = 20;
	localparam int FRAME_BITS_DEF = 16;

	// Request codes carried in the low bits of the input tdata
	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// Control part of the search token that walks the cell chain
	typedef struct packed {
		logic    vld;
		action_t act;
		logic    matched;
		logic    free_found;
	} tok_ctl_t;

endpackage

// File: src/fifo_tlb_core.sv
// Channel  Dir  Payload (tdata, lowest bit up)              Transfer
// s_*      in   action[1:0], page, frame, zero pad           s_tvalid & s_tready
// m_*      out  hit, frame_out, zero pad                     m_tvalid & m_tready
//
// Lookup, insert and remove occupy the block until done: it accepts the
// request, the search token walks the cell chain one cell per cycle, and
// the finish step fills a slot or loads the result register.
// Clear is done at its transfer.
// Reset clears all valid bits and the replacement pointer at once.
// A lookup result waits in the finish step while the output register is full.
module fifo_tlb_core
	import ftlb_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF,
	localparam int IDX_W     = $clog2(ENTRIES),
	localparam int IN_W      = ((2 + PAGE_BITS + FRAME_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((1 + FRAME_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // action, page, frame, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // hit, frame_out, zero pad
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic                  acc;
	action_t               in_act;
	logic [PAGE_BITS-1:0]  in_page;
	logic [FRAME_BITS-1:0] in_frame;
	logic                  clr;

	tok_ctl_t              tok_ctl   [ENTRIES+1];
	logic [PAGE_BITS-1:0]  tok_page  [ENTRIES+1];
	logic [FRAME_BITS-1:0] tok_frame [ENTRIES+1];
	logic [IDX_W-1:0]      tok_idx   [ENTRIES+1];
	logic [ENTRIES:0]      tok_vld_vec;
	logic [ENTRIES-1:0]    valid_vec;

	tok_ctl_t              fin_ctl_q;
	logic [PAGE_BITS-1:0]  fin_page_q;
	logic [FRAME_BITS-1:0] fin_frame_q;
	logic [IDX_W-1:0]      fin_idx_q;
	logic [IDX_W-1:0]      ptr_q;
	logic                  m_tvalid_q;
	logic                  hit_q;
	logic [FRAME_BITS-1:0] frame_out_q;
	logic                  res_load;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;

	// Unpack the request
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign in_act   = action_t'(s_tdata[1:0]);
	assign in_page  = s_tdata[2 +: PAGE_BITS];
	assign in_frame = s_tdata[2 + PAGE_BITS +: FRAME_BITS];
	assign clr      = acc && (in_act == ACT_CLEAR);

	// Launch the search token into the first cell
	always_comb begin
		tok_ctl[0].vld        = acc && (in_act != ACT_CLEAR);
		tok_ctl[0].act        = in_act;
		tok_ctl[0].matched    = 1'b0;
		tok_ctl[0].free_found = 1'b0;
		tok_page[0]           = in_page;
		tok_frame[0]          = (in_act == ACT_INSERT) ? in_frame : '0;
		tok_idx[0]            = '0;
	end

	// On an insert that found no match, fill the lowest free slot, or the FIFO slot on a full table
	assign wr_en  = (state_q == ST_FINISH) && (fin_ctl_q.act == ACT_INSERT) &&
	                !fin_ctl_q.matched;
	assign wr_idx = fin_ctl_q.free_found ? fin_idx_q : ptr_q;

	// Load the result register once it is free or being drained
	assign res_load = (state_q == ST_FINISH) && (fin_ctl_q.act == ACT_LOOKUP) &&
	                  (!m_tvalid_q || m_tready);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ftlb_cell #(
			.IDX        (i),
			.IDX_W      (IDX_W),
			.PAGE_BITS  (PAGE_BITS),
			.FRAME_BITS (FRAME_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tin_ctl    (tok_ctl[i]),
			.tin_page   (tok_page[i]),
			.tin_frame  (tok_frame[i]),
			.tin_idx    (tok_idx[i]),
			.tout_ctl   (tok_ctl[i+1]),
			.tout_page  (tok_page[i+1]),
			.tout_frame (tok_frame[i+1]),
			.tout_idx   (tok_idx[i+1]),
			.wr_en      (wr_en),
			.wr_idx     (wr_idx),
			.wr_page    (fin_page_q),
			.wr_frame   (fin_frame_q),
			.clr        (clr),
			.valid      (valid_vec[i])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
		assign tok_vld_vec[i] = tok_ctl[i].vld;
	end

	// Sequence one request at a time and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_ctl_q   <= '0;
			fin_page_q  <= '0;
			fin_frame_q <= '0;
			fin_idx_q   <= '0;
			ptr_q       <= '0;
			m_tvalid_q  <= 1'b0;
			hit_q       <= 1'b0;
			frame_out_q <= '0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (clr) begin
						ptr_q <= '0;
					end else if (acc) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (tok_ctl[ENTRIES].vld) begin
						fin_ctl_q   <= tok_ctl[ENTRIES];
						fin_page_q  <= tok_page[ENTRIES];
						fin_frame_q <= tok_frame[ENTRIES];
						fin_idx_q   <= tok_idx[ENTRIES];
						state_q     <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					case (fin_ctl_q.act)
						ACT_LOOKUP: begin
							if (res_load) begin
								hit_q       <= fin_ctl_q.matched;
								frame_out_q <= fin_ctl_q.matched ? fin_frame_q : '0;
								state_q     <= ST_IDLE;
							end
						end
						ACT_INSERT: begin
							if (!fin_ctl_q.matched && !fin_ctl_q.free_found) begin
								ptr_q <= (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 :
								         ptr_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({frame_out_q, hit_q});

	// At most one token walks the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld_vec) <= 1)
		else $error("more than one search token in the cell chain");

	// No token in flight while new requests are taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (tok_vld_vec[ENTRIES:1] == '0))
		else $error("request taken while a search is in progress");

	// Replacement pointer stays inside the table
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptr_q) < ENTRIES)
		else $error("replacement pointer out of range");

	// Clear leaves no valid entry behind
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (valid_vec == '0))
		else $error("entry still valid after clear");

	// A fill only happens in the step right after the walk
	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ($past(state_q) == ST_WALK))
		else $error("slot fill outside the finish step");

endmodule

// File: src/ftlb_cell.sv
module ftlb_cell
	import ftlb_pkg::*;
#(
	parameter int IDX        = 0,
	parameter int IDX_W      = $clog2(ENTRIES_DEF),
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// token from the previous cell
	input  tok_ctl_t              tin_ctl,
	input  logic [PAGE_BITS-1:0]  tin_page,
	input  logic [FRAME_BITS-1:0] tin_frame,
	input  logic [IDX_W-1:0]      tin_idx,
	// token to the next cell
	output tok_ctl_t              tout_ctl,
	output logic [PAGE_BITS-1:0]  tout_page,
	output logic [FRAME_BITS-1:0] tout_frame,
	output logic [IDX_W-1:0]      tout_idx,
	// broadcast fill and clear
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [PAGE_BITS-1:0]  wr_page,
	input  logic [FRAME_BITS-1:0] wr_frame,
	input  logic                  clr,
	output logic                  valid
);

	logic                  valid_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_q;
	tok_ctl_t              tok_ctl_q;
	logic [PAGE_BITS-1:0]  tok_page_q;
	logic [FRAME_BITS-1:0] tok_frame_q;
	logic [IDX_W-1:0]      tok_idx_q;
	logic                  hit;
	logic                  free;
	logic                  wr_here;

	// First valid match along the chain claims the token
	assign hit     = tin_ctl.vld && valid_q && !tin_ctl.matched && (page_q == tin_page);
	assign free    = tin_ctl.vld && !valid_q && !tin_ctl.free_found;
	assign wr_here = wr_en && (wr_idx == IDX_W'(IDX));

	// Entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (wr_here) begin
			valid_q <= 1'b1;
		end else if (hit && tin_ctl.act == ACT_REMOVE) begin
			valid_q <= 1'b0;
		end
	end

	// Entry page and frame
	always_ff @(posedge clk) begin
		if (wr_here) begin
			page_q  <= wr_page;
			frame_q <= wr_frame;
		end else if (hit && tin_ctl.act == ACT_INSERT) begin
			frame_q <= tin_frame;
		end
	end

	// Advance the token control to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ctl_q <= '0;
		end else begin
			tok_ctl_q.vld        <= tin_ctl.vld;
			tok_ctl_q.act        <= tin_ctl.act;
			tok_ctl_q.matched    <= tin_ctl.matched | hit;
			tok_ctl_q.free_found <= tin_ctl.free_found | free;
		end
	end

	// Advance the token payload; a lookup hit picks up this frame
	always_ff @(posedge clk) begin
		tok_page_q  <= tin_page;
		tok_frame_q <= (hit && tin_ctl.act == ACT_LOOKUP) ? frame_q : tin_frame;
		tok_idx_q   <= free ? IDX_W'(IDX) : tin_idx;
	end

	assign tout_ctl   = tok_ctl_q;
	assign tout_page  = tok_page_q;
	assign tout_frame = tok_frame_q;
	assign tout_idx   = tok_idx_q;
	assign valid      = valid_q;

endmodule
